// ===== hdl/gillespie_predator_prey_step_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef GILLESPIE_PREDATOR_PREY_STEP_CORE_DEFINES_SVH
`define GILLESPIE_PREDATOR_PREY_STEP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GPP_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gpp check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during rst.
`define GPP_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gpp check failed: next-cycle rule");

`endif

// ===== hdl/gpp_pkg.sv =====
`timescale 1ns / 1ps

package gpp_pkg;

  // Step limit and ln(2) in Q0.32
  localparam logic [19:0] STEP_LIMIT = 20'd1000000;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;

  // Result status codes
  localparam logic [2:0] ST_EVENT     = 3'd0;
  localparam logic [2:0] ST_HORIZON   = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_LIMIT     = 3'd3;
  localparam logic [2:0] ST_RESTARTED = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_BIRTH     = 3'd0;
  localparam logic [2:0] CFG_PREDATION = 3'd1;
  localparam logic [2:0] CFG_DEATH     = 3'd2;
  localparam logic [2:0] CFG_START_PREY = 3'd3;
  localparam logic [2:0] CFG_START_PRED = 3'd4;
  localparam logic [2:0] CFG_HORIZON   = 3'd5;

  // Iteration counts (value loaded is count - 1)
  localparam logic [5:0] LOG_ITERS_M1 = 6'd31;
  localparam logic [5:0] DIV_ITERS_M1 = 6'd45;

  typedef enum logic [4:0] {
    S_IDLE, S_EVAL, S_RESTART, S_MUL_PP, S_MUL_R1, S_MUL_R2, S_MUL_R3,
    S_SUM12, S_SUMTOT, S_ZCHK, S_LOG_INIT, S_LOG_SQ, S_LN_A, S_LN_B,
    S_LN_SUM, S_DIV_INIT, S_DIV_STEP, S_PICK_LO, S_PICK_HI, S_PICK_SUM,
    S_APPLY, S_PUBLISH
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_RESTART, CMD_MUL_PP, CMD_MUL_R1, CMD_MUL_R2,
    CMD_MUL_R3, CMD_SUM12, CMD_SUMTOT, CMD_LOG_INIT, CMD_LOG_SQ, CMD_LN_A,
    CMD_LN_B, CMD_LN_SUM, CMD_DIV_INIT, CMD_DIV_STEP, CMD_PICK_LO,
    CMD_PICK_HI, CMD_PICK_SUM, CMD_APPLY, CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] code;
  } ctl_t;

  typedef struct packed {
    logic act_step;
    logic horizon_hit;
    logic limit_hit;
    logic total_zero;
    logic iter_last;
  } dp_stat_t;

endpackage

// ===== hdl/gpp_ctrl.sv =====
`timescale 1ns / 1ps

module gpp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gpp_pkg::dp_stat_t st,
  output gpp_pkg::ctl_t     ctl
);

  gpp_pkg::state_t state, state_next;
  logic [2:0] code, code_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == gpp_pkg::S_IDLE);

  // State and pending status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpp_pkg::S_IDLE;
      code  <= gpp_pkg::ST_EVENT;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // Output holding register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == gpp_pkg::S_PUBLISH && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    code_next  = code;
    case (state)
      gpp_pkg::S_IDLE: if (in_valid) state_next = gpp_pkg::S_EVAL;
      gpp_pkg::S_EVAL: begin
        if (!st.act_step) begin
          state_next = gpp_pkg::S_RESTART;
          code_next  = gpp_pkg::ST_RESTARTED;
        end else if (st.horizon_hit) begin
          state_next = gpp_pkg::S_PUBLISH;
          code_next  = gpp_pkg::ST_HORIZON;
        end else if (st.limit_hit) begin
          state_next = gpp_pkg::S_PUBLISH;
          code_next  = gpp_pkg::ST_LIMIT;
        end else begin
          state_next = gpp_pkg::S_MUL_PP;
        end
      end
      gpp_pkg::S_RESTART:  state_next = gpp_pkg::S_PUBLISH;
      gpp_pkg::S_MUL_PP:   state_next = gpp_pkg::S_MUL_R1;
      gpp_pkg::S_MUL_R1:   state_next = gpp_pkg::S_MUL_R2;
      gpp_pkg::S_MUL_R2:   state_next = gpp_pkg::S_MUL_R3;
      gpp_pkg::S_MUL_R3:   state_next = gpp_pkg::S_SUM12;
      gpp_pkg::S_SUM12:    state_next = gpp_pkg::S_SUMTOT;
      gpp_pkg::S_SUMTOT:   state_next = gpp_pkg::S_ZCHK;
      gpp_pkg::S_ZCHK: begin
        if (st.total_zero) begin
          state_next = gpp_pkg::S_PUBLISH;
          code_next  = gpp_pkg::ST_ZERO;
        end else begin
          state_next = gpp_pkg::S_LOG_INIT;
        end
      end
      gpp_pkg::S_LOG_INIT: state_next = gpp_pkg::S_LOG_SQ;
      gpp_pkg::S_LOG_SQ:   if (st.iter_last) state_next = gpp_pkg::S_LN_A;
      gpp_pkg::S_LN_A:     state_next = gpp_pkg::S_LN_B;
      gpp_pkg::S_LN_B:     state_next = gpp_pkg::S_LN_SUM;
      gpp_pkg::S_LN_SUM:   state_next = gpp_pkg::S_DIV_INIT;
      gpp_pkg::S_DIV_INIT: state_next = gpp_pkg::S_DIV_STEP;
      gpp_pkg::S_DIV_STEP: if (st.iter_last) state_next = gpp_pkg::S_PICK_LO;
      gpp_pkg::S_PICK_LO:  state_next = gpp_pkg::S_PICK_HI;
      gpp_pkg::S_PICK_HI:  state_next = gpp_pkg::S_PICK_SUM;
      gpp_pkg::S_PICK_SUM: state_next = gpp_pkg::S_APPLY;
      gpp_pkg::S_APPLY: begin
        state_next = gpp_pkg::S_PUBLISH;
        code_next  = gpp_pkg::ST_EVENT;
      end
      gpp_pkg::S_PUBLISH:  if (slot_free) state_next = gpp_pkg::S_IDLE;
      default:             state_next = gpp_pkg::S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    ctl.code = code;
    case (state)
      gpp_pkg::S_IDLE:     ctl.cmd = in_valid ? gpp_pkg::CMD_LOAD : gpp_pkg::CMD_NONE;
      gpp_pkg::S_RESTART:  ctl.cmd = gpp_pkg::CMD_RESTART;
      gpp_pkg::S_MUL_PP:   ctl.cmd = gpp_pkg::CMD_MUL_PP;
      gpp_pkg::S_MUL_R1:   ctl.cmd = gpp_pkg::CMD_MUL_R1;
      gpp_pkg::S_MUL_R2:   ctl.cmd = gpp_pkg::CMD_MUL_R2;
      gpp_pkg::S_MUL_R3:   ctl.cmd = gpp_pkg::CMD_MUL_R3;
      gpp_pkg::S_SUM12:    ctl.cmd = gpp_pkg::CMD_SUM12;
      gpp_pkg::S_SUMTOT:   ctl.cmd = gpp_pkg::CMD_SUMTOT;
      gpp_pkg::S_LOG_INIT: ctl.cmd = gpp_pkg::CMD_LOG_INIT;
      gpp_pkg::S_LOG_SQ:   ctl.cmd = gpp_pkg::CMD_LOG_SQ;
      gpp_pkg::S_LN_A:     ctl.cmd = gpp_pkg::CMD_LN_A;
      gpp_pkg::S_LN_B:     ctl.cmd = gpp_pkg::CMD_LN_B;
      gpp_pkg::S_LN_SUM:   ctl.cmd = gpp_pkg::CMD_LN_SUM;
      gpp_pkg::S_DIV_INIT: ctl.cmd = gpp_pkg::CMD_DIV_INIT;
      gpp_pkg::S_DIV_STEP: ctl.cmd = gpp_pkg::CMD_DIV_STEP;
      gpp_pkg::S_PICK_LO:  ctl.cmd = gpp_pkg::CMD_PICK_LO;
      gpp_pkg::S_PICK_HI:  ctl.cmd = gpp_pkg::CMD_PICK_HI;
      gpp_pkg::S_PICK_SUM: ctl.cmd = gpp_pkg::CMD_PICK_SUM;
      gpp_pkg::S_APPLY:    ctl.cmd = gpp_pkg::CMD_APPLY;
      gpp_pkg::S_PUBLISH:  ctl.cmd = slot_free ? gpp_pkg::CMD_PUBLISH : gpp_pkg::CMD_NONE;
      default:             ctl.cmd = gpp_pkg::CMD_NONE;
    endcase
  end

endmodule

// ===== hdl/gpp_dp.sv =====
`timescale 1ns / 1ps

module gpp_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  input  logic              action,
  input  logic [31:0]       draw_time,
  input  logic [31:0]       draw_event,
  input  gpp_pkg::ctl_t     ctl,
  output gpp_pkg::dp_stat_t st,
  output logic [47:0]       sim_time,
  output logic [15:0]       prey,
  output logic [15:0]       predators,
  output logic [2:0]        status
);

  // Configuration
  logic [31:0] birth_rate, predation_rate, death_rate;
  logic [15:0] start_prey, start_predators;
  logic [47:0] horizon;

  // Simulation state
  logic [47:0] time_now;
  logic [15:0] prey_now, pred_now;
  logic [19:0] steps_done;

  // Working registers
  logic        act;
  logic [31:0] dt_draw, de_draw;
  logic [63:0] prod;
  logic [31:0] pp;
  logic [47:0] r1, r3;
  logic [63:0] r2;
  logic [64:0] s12, tot, pick;
  logic [31:0] mant, frac;
  logic [5:0]  nexp, iter;
  logic [37:0] nl;
  logic [45:0] dvd, quo;
  logic [64:0] rem;

  // Combinational helpers
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq;
  logic [31:0] dsel, mant_init;
  logic [4:0]  nidx;
  logic [37:0] nl2;
  logic [65:0] rs, rs_diff;
  logic        qbit;
  logic [48:0] tsum;
  logic [64:0] pick_add;

  assign st.act_step    = act;
  assign st.horizon_hit = (time_now >= horizon);
  assign st.limit_hit   = (steps_done >= gpp_pkg::STEP_LIMIT);
  assign st.total_zero  = (tot == 65'd0);
  assign st.iter_last   = (iter == 6'd0);

  // Shared 32x32 multiplier, operand select per command
  always_comb begin
    case (ctl.cmd)
      gpp_pkg::CMD_MUL_PP: begin mul_a = {16'd0, prey_now}; mul_b = {16'd0, pred_now}; end
      gpp_pkg::CMD_MUL_R1: begin mul_a = birth_rate;        mul_b = {16'd0, prey_now}; end
      gpp_pkg::CMD_MUL_R2: begin mul_a = predation_rate;    mul_b = pp;                end
      gpp_pkg::CMD_MUL_R3: begin mul_a = death_rate;        mul_b = {16'd0, pred_now}; end
      gpp_pkg::CMD_LOG_SQ: begin mul_a = mant;              mul_b = mant;              end
      gpp_pkg::CMD_LN_A:   begin mul_a = {26'd0, nl2[37:32]}; mul_b = gpp_pkg::LN2_Q32; end
      gpp_pkg::CMD_LN_B:   begin mul_a = nl2[31:0];         mul_b = gpp_pkg::LN2_Q32;  end
      gpp_pkg::CMD_PICK_LO: begin mul_a = de_draw;          mul_b = tot[31:0];         end
      gpp_pkg::CMD_PICK_HI: begin mul_a = de_draw;          mul_b = tot[63:32];        end
      default:             begin mul_a = 32'd0;             mul_b = 32'd0;             end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Log front end: leading one of the draw, Q1.31 mantissa
  always_comb begin
    dsel = (dt_draw == 32'd0) ? 32'd1 : dt_draw;
    nidx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (dsel[i]) nidx = i[4:0];
    end
    mant_init = dsel << (5'd31 - nidx);
    sq  = mul_p[63:31];
    nl2 = {nexp, 32'd0} - {6'd0, frac};
  end

  // Restoring divide step and final updates
  always_comb begin
    rs       = {rem, dvd[45]};
    rs_diff  = rs - {1'b0, tot};
    qbit     = (rs >= {1'b0, tot});
    tsum     = {1'b0, time_now} + {3'd0, quo};
    pick_add = tot[64] ? {1'b0, de_draw, 32'd0} : 65'd0;
  end

  // Configuration and simulation state
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_rate      <= 32'd196608;
      predation_rate  <= 32'd655;
      death_rate      <= 32'd327680;
      start_prey      <= 16'd50;
      start_predators <= 16'd20;
      horizon         <= 48'd1677721600;
      time_now        <= 48'd0;
      prey_now        <= 16'd0;
      pred_now        <= 16'd0;
      steps_done      <= 20'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gpp_pkg::CFG_BIRTH:      birth_rate      <= cfg_data[31:0];
          gpp_pkg::CFG_PREDATION:  predation_rate  <= cfg_data[31:0];
          gpp_pkg::CFG_DEATH:      death_rate      <= cfg_data[31:0];
          gpp_pkg::CFG_START_PREY: start_prey      <= cfg_data[15:0];
          gpp_pkg::CFG_START_PRED: start_predators <= cfg_data[15:0];
          gpp_pkg::CFG_HORIZON:    horizon         <= cfg_data;
          default: ;
        endcase
      end
      case (ctl.cmd)
        gpp_pkg::CMD_RESTART: begin
          time_now   <= 48'd0;
          prey_now   <= start_prey;
          pred_now   <= start_predators;
          steps_done <= 20'd0;
        end
        gpp_pkg::CMD_APPLY: begin
          time_now   <= tsum[48] ? {48{1'b1}} : tsum[47:0];
          steps_done <= steps_done + 20'd1;
          if (pick < {17'd0, r1}) begin
            if (prey_now != 16'hFFFF) prey_now <= prey_now + 16'd1;
          end else if (pick < s12) begin
            if (prey_now != 16'd0) prey_now <= prey_now - 16'd1;
            if (pred_now != 16'hFFFF) pred_now <= pred_now + 16'd1;
          end else begin
            if (pred_now != 16'd0) pred_now <= pred_now - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (ctl.cmd)
      gpp_pkg::CMD_LOAD: begin
        act     <= action;
        dt_draw <= draw_time;
        de_draw <= draw_event;
      end
      gpp_pkg::CMD_MUL_R1: pp <= prod[31:0];
      gpp_pkg::CMD_MUL_R2: r1 <= prod[47:0];
      gpp_pkg::CMD_MUL_R3: r2 <= prod;
      gpp_pkg::CMD_SUM12: begin
        r3  <= prod[47:0];
        s12 <= {17'd0, r1} + {1'b0, r2};
      end
      gpp_pkg::CMD_SUMTOT: tot <= s12 + {17'd0, r3};
      gpp_pkg::CMD_LOG_INIT: begin
        mant <= mant_init;
        nexp <= 6'd32 - {1'b0, nidx};
        frac <= 32'd0;
        iter <= gpp_pkg::LOG_ITERS_M1;
      end
      gpp_pkg::CMD_LOG_SQ: begin
        // square, renormalize, shift out one fraction bit
        mant <= sq[32] ? sq[32:1] : sq[31:0];
        frac <= {frac[30:0], sq[32]};
        iter <= iter - 6'd1;
      end
      gpp_pkg::CMD_LN_B:   nl <= prod[37:0];
      gpp_pkg::CMD_LN_SUM: nl <= nl + {6'd0, prod[63:32]};
      gpp_pkg::CMD_DIV_INIT: begin
        dvd  <= {nl, 8'd0};
        rem  <= 65'd0;
        quo  <= 46'd0;
        iter <= gpp_pkg::DIV_ITERS_M1;
      end
      gpp_pkg::CMD_DIV_STEP: begin
        rem  <= qbit ? rs_diff[64:0] : rs[64:0];
        quo  <= {quo[44:0], qbit};
        dvd  <= {dvd[44:0], 1'b0};
        iter <= iter - 6'd1;
      end
      gpp_pkg::CMD_PICK_HI:  pick <= {33'd0, prod[63:32]};
      gpp_pkg::CMD_PICK_SUM: pick <= pick + {1'b0, prod} + pick_add;
      gpp_pkg::CMD_PUBLISH: begin
        sim_time  <= time_now;
        prey      <= prey_now;
        predators <= pred_now;
        status    <= ctl.code;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/gillespie_predator_prey_step_core.sv =====
`timescale 1ns / 1ps
// Gillespie predator-prey step engine.
// Input channel (in_valid/in_ready): action, draw_time, draw_event. action 0
// restarts from the start counts at time zero; action 1 takes one stochastic step.
// Output channel (out_valid/out_ready): sim_time, prey, predators, status, one
// transaction per input transaction, in order.
// Config port: cfg_we/cfg_index/cfg_data, write only, taken in any cycle;
// write it only while the engine is idle.
// Paths from accept to publish: a held step (horizon or step limit) publishes
// straight from decode, a restart loads the start state first, a zero total
// rate publishes after the sums, and a full step runs decode, products and sums
// on the shared 32x32 multiplier, the log unit (setup and 32 squaring passes),
// ln, the restoring divide by the 65-bit total rate and the event pick, then
// apply and publish.
// One transaction at a time: in_ready is high only when idle, so a new
// transaction is accepted only after the last one is published.
// A finished result sits in the output register; a new transaction may be
// accepted while it waits. If the receiver stalls, the next result waits in
// the engine until the output register frees.
// Reset: config returns to its defaults, time and counts go to zero, no
// result is pending.
module gillespie_predator_prey_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] draw_time,
  input  logic [31:0] draw_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] sim_time,
  output logic [15:0] prey,
  output logic [15:0] predators,
  output logic [2:0]  status
);

  gpp_pkg::ctl_t     ctl;
  gpp_pkg::dp_stat_t st;

  gpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .ctl       (ctl)
  );

  gpp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .draw_time  (draw_time),
    .draw_event (draw_event),
    .ctl        (ctl),
    .st         (st),
    .sim_time   (sim_time),
    .prey       (prey),
    .predators  (predators),
    .status     (status)
  );

endmodule

// ===== hdl/gpp_checker.sv =====
`timescale 1ns / 1ps
`include "gillespie_predator_prey_step_core_defines.svh"

module gpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] sim_time,
  input logic [15:0] prey,
  input logic [15:0] predators,
  input logic [2:0]  status
);

  // A stalled result stays
  `GPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sim_time) && $stable(prey) && $stable(predators) && $stable(status))

  // Engine goes busy after taking a transaction
  `GPP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Restart reports time zero
  `GPP_ASSERT_SAME(a_restart_time, out_valid && status == gpp_pkg::ST_RESTARTED, sim_time == 48'd0)

  // Only defined status codes appear
  `GPP_ASSERT_SAME(a_status_code, out_valid, status <= gpp_pkg::ST_RESTARTED)

endmodule

bind gillespie_predator_prey_step_core gpp_checker u_gpp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sim_time  (sim_time),
  .prey      (prey),
  .predators (predators),
  .status    (status)
);
